// ----- src/fbsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbsc_pkg
// shared types and constants of the frustum box / sphere cull block
// ----------------------------------------------------------------------------
package fbsc_pkg;

	// parameter defaults
	localparam int PLANE_COUNT_DEF = 6;
	localparam int COORD_WIDTH_DEF = 32;

	// fixed field widths of the stream payload
	localparam int FIELD_W      = 32;
	localparam int CMD_W        = 2;
	localparam int IDX_W        = 3;
	localparam int VERDICT_W    = 2;
	localparam int FRAC_BITS    = 16;

	// s_tdata layout, lowest bit up
	localparam int OFS_IDX      = 0;
	localparam int OFS_AX       = OFS_IDX + IDX_W;
	localparam int OFS_AY       = OFS_AX + FIELD_W;
	localparam int OFS_AZ       = OFS_AY + FIELD_W;
	localparam int OFS_BX       = OFS_AZ + FIELD_W;
	localparam int OFS_BY       = OFS_BX + FIELD_W;
	localparam int OFS_BZ       = OFS_BY + FIELD_W;
	localparam int OFS_SCALAR   = OFS_BZ + FIELD_W;
	localparam int OFS_HAS_SIZE = OFS_SCALAR + FIELD_W;
	localparam int IN_BITS      = OFS_HAS_SIZE + 1;
	localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int S_TUSER_W    = CMD_W;
	localparam int M_TDATA_W    = ((VERDICT_W + 7) / 8) * 8;

	// commands
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BOX    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SPHERE = 2'd2;

	// verdicts
	localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} fbsc_state_t;

	// control travelling with one dot product request
	typedef struct packed {
		logic valid;
		logic pass;    // 0 positive corner or sphere, 1 negative corner
	} dot_ctl_t;

	// status coming back from the dot product unit
	typedef struct packed {
		logic valid;
		logic pass;
		logic neg;     // plane distance below zero
		logic busy;    // a request sits in the product stage
	} dot_res_t;

endpackage : fbsc_pkg
`default_nettype wire

// ----- src/fbsc_dot.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbsc_dot
// shared plane distance unit: three products, floor to q16.16, sum and sign
// ----------------------------------------------------------------------------
module fbsc_dot #(
	parameter int COORD_WIDTH = fbsc_pkg::COORD_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  fbsc_pkg::dot_ctl_t            ctl,
	input  wire signed [COORD_WIDTH-1:0]  n_x,
	input  wire signed [COORD_WIDTH-1:0]  n_y,
	input  wire signed [COORD_WIDTH-1:0]  n_z,
	input  wire signed [COORD_WIDTH-1:0]  q_x,
	input  wire signed [COORD_WIDTH-1:0]  q_y,
	input  wire signed [COORD_WIDTH-1:0]  q_z,
	input  wire signed [COORD_WIDTH:0]    addend,
	output fbsc_pkg::dot_res_t            res
);
	import fbsc_pkg::*;

	localparam int PW   = 2 * COORD_WIDTH;
	localparam int FW   = PW - FRAC_BITS;
	localparam int SUMW = FW + 3;

	logic signed [PW-1:0]       px_s1, py_s1, pz_s1;
	logic signed [COORD_WIDTH:0] add_s1;
	dot_ctl_t                   ctl_s1;
	logic                       valid_s2, pass_s2, neg_s2;

	logic [FW-1:0]   fx, fy, fz;
	logic [SUMW-1:0] sum;

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		px_s1  <= n_x * q_x;
		py_s1  <= n_y * q_y;
		pz_s1  <= n_z * q_z;
		add_s1 <= addend;
	end

	// floor to q16.16 by dropping the fraction, then sign-extended sum
	always_comb begin
		fx  = px_s1[PW-1:FRAC_BITS];
		fy  = py_s1[PW-1:FRAC_BITS];
		fz  = pz_s1[PW-1:FRAC_BITS];
		sum = {{3{fx[FW-1]}}, fx} + {{3{fy[FW-1]}}, fy} + {{3{fz[FW-1]}}, fz}
			+ {{(SUMW-COORD_WIDTH-1){add_s1[COORD_WIDTH]}}, add_s1};
	end

	// stage 2: sign of the distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		pass_s2 <= ctl_s1.pass;
		neg_s2  <= sum[SUMW-1];
	end

	always_comb begin
		res.valid = valid_s2;
		res.pass  = pass_s2;
		res.neg   = neg_s2;
		res.busy  = ctl_s1.valid;
	end

endmodule : fbsc_dot
`default_nettype wire

// ----- src/frustum_box_sphere_cull.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull
// view frustum cull of axis-aligned boxes and spheres against stored planes
// ----------------------------------------------------------------------------
// Holds PLANE_COUNT planes (normal and offset, signed q16.16). A load transfer
// (tuser command load) writes one plane and gives no result; loads with an
// index past the plane count and command 3 are dropped. A box test yields
// inside, intersecting or outside; a sphere test yields inside or
// outside. All planes must be loaded before the first test. One shared unit
// with three multipliers evaluates one plane distance per cycle: a box test
// runs two passes per plane (positive and negative corner), a sphere test one,
// and a box without size goes straight to the inside verdict. The input is not
// ready while a test runs; a finished verdict waits in the output register
// while the next item is taken.
// ----------------------------------------------------------------------------
module frustum_box_sphere_cull #(
	parameter int PLANE_COUNT = fbsc_pkg::PLANE_COUNT_DEF,
	parameter int COORD_WIDTH = fbsc_pkg::COORD_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// plane_index, coord_a_x, coord_a_y, coord_a_z, coord_b_x, coord_b_y,
	// coord_b_z, scalar_value, box_has_size, zero fill
	input  wire  [fbsc_pkg::S_TDATA_W-1:0]   s_tdata,
	// command
	input  wire  [fbsc_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// verdict, zero fill
	output logic [fbsc_pkg::M_TDATA_W-1:0]   m_tdata
);
	import fbsc_pkg::*;

	localparam int KW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(PLANE_COUNT - 1);
	localparam int CW = COORD_WIDTH;

	// input field views
	logic [CMD_W-1:0]     in_cmd;
	logic [IDX_W-1:0]     in_idx;
	logic signed [CW-1:0] in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_sc;
	logic                 in_has_size;

	assign in_cmd      = s_tuser[CMD_W-1:0];
	assign in_idx      = s_tdata[OFS_IDX +: IDX_W];
	assign in_ax       = s_tdata[OFS_AX +: CW];
	assign in_ay       = s_tdata[OFS_AY +: CW];
	assign in_az       = s_tdata[OFS_AZ +: CW];
	assign in_bx       = s_tdata[OFS_BX +: CW];
	assign in_by       = s_tdata[OFS_BY +: CW];
	assign in_bz       = s_tdata[OFS_BZ +: CW];
	assign in_sc       = s_tdata[OFS_SCALAR +: CW];
	assign in_has_size = s_tdata[OFS_HAS_SIZE];

	// plane store, undefined until loaded
	logic signed [CW-1:0] pl_nx_q [PLANE_COUNT];
	logic signed [CW-1:0] pl_ny_q [PLANE_COUNT];
	logic signed [CW-1:0] pl_nz_q [PLANE_COUNT];
	logic signed [CW-1:0] pl_d_q  [PLANE_COUNT];

	// operands of the running test
	logic signed [CW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, rad_q;
	logic                 sphere_q;

	// sequencer
	fbsc_state_t     state_q, state_d;
	logic [KW-1:0]   k_q;
	logic            pass_q;
	logic            flag_out_q, flag_int_q;
	logic            m_tvalid_q;
	logic [VERDICT_W-1:0] verdict_q;

	logic            in_xfer, load_xfer, start, issue, last_issue, out_load;
	dot_ctl_t        dot_ctl;
	dot_res_t        dot_res;

	// operand selection for the current plane
	logic signed [CW-1:0] n_x, n_y, n_z, q_x, q_y, q_z, d_cur;
	logic signed [CW:0]   addend;

	assign in_xfer    = s_tvalid && s_tready;
	assign load_xfer  = in_xfer && (in_cmd == CMD_LOAD);
	assign last_issue = (k_q == K_LAST) && (sphere_q || pass_q);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		start    = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (in_cmd == CMD_BOX || in_cmd == CMD_SPHERE)) begin
					start = 1'b1;
					// a box without size goes straight to the verdict: inside
					if (in_cmd == CMD_BOX && !in_has_size) begin
						state_d = ST_DRAIN;
					end else begin
						state_d = ST_ISSUE;
					end
				end
			end
			ST_ISSUE: begin
				issue = 1'b1;
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the unit to empty and the output register to free up
				if (!dot_res.busy && !dot_res.valid && (!m_tvalid_q || m_tready)) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// plane and pass counters, verdict flags, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= '0;
			pass_q     <= 1'b0;
			sphere_q   <= 1'b0;
			flag_out_q <= 1'b0;
			flag_int_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (start) begin
				k_q        <= '0;
				pass_q     <= 1'b0;
				sphere_q   <= (in_cmd == CMD_SPHERE);
				flag_out_q <= 1'b0;
				flag_int_q <= 1'b0;
			end else begin
				if (issue) begin
					// box: positive then negative corner per plane
					if (!sphere_q && !pass_q) begin
						pass_q <= 1'b1;
					end else begin
						pass_q <= 1'b0;
						k_q    <= k_q + 1'b1;
					end
				end
				if (dot_res.valid && dot_res.neg) begin
					if (dot_res.pass) begin
						flag_int_q <= 1'b1;
					end else begin
						flag_out_q <= 1'b1;
					end
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		for (int i = 0; i < PLANE_COUNT; i++) begin
			if (load_xfer && (int'(in_idx) == i)) begin
				pl_nx_q[i] <= in_ax;
				pl_ny_q[i] <= in_ay;
				pl_nz_q[i] <= in_az;
				pl_d_q[i]  <= in_sc;
			end
		end
		if (start) begin
			ax_q  <= in_ax;
			ay_q  <= in_ay;
			az_q  <= in_az;
			bx_q  <= in_bx;
			by_q  <= in_by;
			bz_q  <= in_bz;
			rad_q <= in_sc;
		end
		if (out_load) begin
			if (flag_out_q) begin
				verdict_q <= VERDICT_OUTSIDE;
			end else if (flag_int_q) begin
				verdict_q <= VERDICT_INTERSECT;
			end else begin
				verdict_q <= VERDICT_INSIDE;
			end
		end
	end

	// corner pick: maximum where the normal is non-negative on the positive
	// corner pass, the other way round on the negative corner pass
	always_comb begin
		n_x   = pl_nx_q[k_q];
		n_y   = pl_ny_q[k_q];
		n_z   = pl_nz_q[k_q];
		d_cur = pl_d_q[k_q];
		q_x   = ((!n_x[CW-1]) ^ pass_q) ? bx_q : ax_q;
		q_y   = ((!n_y[CW-1]) ^ pass_q) ? by_q : ay_q;
		q_z   = ((!n_z[CW-1]) ^ pass_q) ? bz_q : az_q;
		if (sphere_q) begin
			// sphere uses the centre and folds the radius into the offset
			q_x    = ax_q;
			q_y    = ay_q;
			q_z    = az_q;
			addend = {d_cur[CW-1], d_cur} + {rad_q[CW-1], rad_q};
		end else begin
			addend = {d_cur[CW-1], d_cur};
		end
		dot_ctl.valid = issue;
		dot_ctl.pass  = pass_q;
	end

	fbsc_dot #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dot_ctl),
		.n_x    (n_x),
		.n_y    (n_y),
		.n_z    (n_z),
		.q_x    (q_x),
		.q_y    (q_y),
		.q_z    (q_z),
		.addend (addend),
		.res    (dot_res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-VERDICT_W){1'b0}}, verdict_q};

	// a distance result always follows a request through the stage 1 and stage 2 registers
	a_res_follows_issue: assert property (@(posedge clk) disable iff (!arst_n)
		dot_res.valid |-> $past(issue, 2))
		else $error("distance result without matching request");

	// nothing is in flight while the block waits for a new item
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!dot_res.valid && !dot_res.busy))
		else $error("distance unit busy while idle");

	// a test transfer always leaves the idle state
	a_test_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (in_cmd == CMD_BOX || in_cmd == CMD_SPHERE))
		|=> (state_q == ST_ISSUE || state_q == ST_DRAIN))
		else $error("test transfer did not start the sequencer");

	// a sphere never reports a negative corner hit
	a_sphere_no_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(sphere_q && state_q != ST_IDLE) |-> !flag_int_q)
		else $error("sphere test marked as intersecting");

	// the verdict is one of the three codes
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[VERDICT_W-1:0] == VERDICT_INSIDE
			|| m_tdata[VERDICT_W-1:0] == VERDICT_INTERSECT
			|| m_tdata[VERDICT_W-1:0] == VERDICT_OUTSIDE))
		else $error("bad verdict code");

endmodule : frustum_box_sphere_cull
`default_nettype wire
